/* rtl/core/q6k_pkg.sv */
`default_nettype none

package q6k_pkg;

    localparam int SUB_WIDTH = 16;
    localparam int CODE_W    = 6;
    localparam int ACT_W     = 8;
    localparam int PROD_W    = 15;
    localparam int PART_W    = 17;
    localparam int DIFF_W    = 20;
    localparam int LANES     = 4;
    localparam int LANE_W    = 2;

    localparam int IN_DATA_W = 296;
    localparam int CFG_ADDR_W = 1;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PER_GROUP = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_GLOBAL_SS = 1'b1;

    localparam logic [31:0] F32_ONE   = 32'h3F80_0000;
    localparam logic [31:0] F32_QNAN  = 32'hFFC0_0000;
    localparam logic [31:0] F32_QUIET = 32'h0040_0000;
    localparam int          F32_BIAS  = 127;
    localparam int          HALF_BIAS_ADJ = 127 - 15;

    // leading zero count of a 32-bit word, 32 when zero
    function automatic logic [5:0] f_lzc32(input logic [31:0] x);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) begin
                n = 6'(31 - i);
            end
        end
        return n;
    endfunction

    // exact conversion of a small signed integer to binary32
    function automatic logic [31:0] f_int_to_f32(input logic signed [DIFF_W-1:0] x);
        logic [DIFF_W-1:0] mag;
        logic [DIFF_W-1:0] nrm;
        logic [5:0]        lz;
        logic [7:0]        ex;
        logic [31:0]       r;
        mag = x[DIFF_W-1] ? DIFF_W'(-x) : DIFF_W'(x);
        lz  = f_lzc32({mag, {(32-DIFF_W){1'b0}}});
        nrm = mag << lz;
        ex  = 8'(F32_BIAS + DIFF_W - 1 - int'(lz));
        if (mag == '0) begin
            r = 32'h0;
        end else begin
            r = {x[DIFF_W-1], ex, nrm[DIFF_W-2:0], {(24-DIFF_W){1'b0}}};
        end
        return r;
    endfunction

    // half to binary32, half subnormals become normals
    function automatic logic [31:0] f_half_to_f32(input logic [15:0] h);
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [5:0]  lz;
        logic [10:0] m;
        logic [31:0] r;
        ex  = h[14:10];
        man = h[9:0];
        lz  = f_lzc32({man, 22'b0});
        m   = {1'b0, man} << (lz + 6'd1);
        if (ex == 5'd0 && man == 10'd0) begin
            r = {h[15], 31'b0};
        end else if (ex == 5'd0) begin
            r = {h[15], 8'(HALF_BIAS_ADJ - int'(lz)), m[9:0], 13'b0};
        end else if (ex == 5'h1F) begin
            r = {h[15], 8'hFF, man, 13'b0};
        end else begin
            r = {h[15], 8'(int'(ex) + HALF_BIAS_ADJ), man, 13'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/q6k_dot.sv */
`default_nettype none

module q6k_dot (
    input  logic                                       i_clk,
    input  logic                                       i_en,
    input  logic [q6k_pkg::SUB_WIDTH*q6k_pkg::CODE_W-1:0] i_codes,
    input  logic [q6k_pkg::SUB_WIDTH*q6k_pkg::ACT_W-1:0]  i_acts,
    input  logic signed [11:0]                         i_asum,
    output logic [31:0]                                o_diff_f
);

    localparam int NPART = q6k_pkg::SUB_WIDTH / 4;

    logic signed [q6k_pkg::PROD_W-1:0] r_prod [q6k_pkg::SUB_WIDTH];
    logic signed [q6k_pkg::PROD_W-1:0] n_prod [q6k_pkg::SUB_WIDTH];
    logic signed [q6k_pkg::PART_W-1:0] r_part [NPART];
    logic signed [q6k_pkg::PART_W-1:0] n_part [NPART];
    logic signed [q6k_pkg::DIFF_W-1:0] r_diff;
    logic signed [q6k_pkg::DIFF_W-1:0] n_diff;
    logic signed [11:0]                r_asum1;
    logic signed [11:0]                r_asum2;
    logic [31:0]                       r_diff_f;

    always_comb begin
        for (int i = 0; i < q6k_pkg::SUB_WIDTH; i++) begin
            n_prod[i] = $signed({{(q6k_pkg::PROD_W-q6k_pkg::CODE_W){1'b0}},
                                 i_codes[q6k_pkg::CODE_W*i +: q6k_pkg::CODE_W]})
                      * $signed({{(q6k_pkg::PROD_W-q6k_pkg::ACT_W){i_acts[8*i+7]}},
                                 i_acts[q6k_pkg::ACT_W*i +: q6k_pkg::ACT_W]});
        end
    end

    always_comb begin
        for (int g = 0; g < NPART; g++) begin
            n_part[g] = r_prod[4*g] + r_prod[4*g+1] + r_prod[4*g+2] + r_prod[4*g+3];
        end
    end

    // dot minus 32 times the supplied sum, exact in twenty bits
    always_comb begin
        n_diff = '0;
        for (int g = 0; g < NPART; g++) begin
            n_diff = n_diff + r_part[g];
        end
        n_diff = n_diff - $signed({{3{r_asum2[11]}}, r_asum2, 5'b0});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod   <= n_prod;
            r_asum1  <= i_asum;
            r_part   <= n_part;
            r_asum2  <= r_asum1;
            r_diff   <= n_diff;
            r_diff_f <= q6k_pkg::f_int_to_f32(r_diff);
        end
    end

    assign o_diff_f = r_diff_f;

endmodule

`default_nettype wire

/* rtl/core/q6k_fmul.sv */
`default_nettype none

module q6k_fmul (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_prod
);

    // unpack and normalize
    logic               a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
    logic [23:0]        sig_a, sig_b;
    logic [5:0]         lz_a, lz_b;
    logic signed [11:0] n_ea, n_eb;
    logic               n_spec;
    logic [31:0]        n_spec_val;
    logic               n_sign;

    logic               r1_sign, r1_spec;
    logic [31:0]        r1_spec_val;
    logic signed [11:0] r1_ea, r1_eb;
    logic [23:0]        r1_ma, r1_mb;

    logic               r2_sign, r2_spec;
    logic [31:0]        r2_spec_val;
    logic signed [11:0] r2_e;
    logic [47:0]        r2_p;

    logic [47:0]        pn, m;
    logic signed [11:0] e;
    logic [5:0]         sh;
    logic [7:0]         field;
    logic               lost, up;
    logic [31:0]        n_res;
    logic [31:0]        r3_res;

    always_comb begin
        a_nan  = (i_a[30:23] == 8'hFF) && (i_a[22:0] != '0);
        a_inf  = (i_a[30:23] == 8'hFF) && (i_a[22:0] == '0);
        a_zero = i_a[30:0] == '0;
        b_nan  = (i_b[30:23] == 8'hFF) && (i_b[22:0] != '0);
        b_inf  = (i_b[30:23] == 8'hFF) && (i_b[22:0] == '0);
        b_zero = i_b[30:0] == '0;
        sig_a  = {i_a[30:23] != 8'd0, i_a[22:0]};
        sig_b  = {i_b[30:23] != 8'd0, i_b[22:0]};
        lz_a   = q6k_pkg::f_lzc32({sig_a, 8'b0});
        lz_b   = q6k_pkg::f_lzc32({sig_b, 8'b0});
        n_ea   = $signed({4'b0, (i_a[30:23] == 8'd0) ? 8'd1 : i_a[30:23]})
               - $signed({6'b0, lz_a});
        n_eb   = $signed({4'b0, (i_b[30:23] == 8'd0) ? 8'd1 : i_b[30:23]})
               - $signed({6'b0, lz_b});
        n_sign = i_a[31] ^ i_b[31];
        n_spec = 1'b1;
        priority if (a_nan) begin
            n_spec_val = i_a | q6k_pkg::F32_QUIET;
        end else if (b_nan) begin
            n_spec_val = i_b | q6k_pkg::F32_QUIET;
        end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
            n_spec_val = q6k_pkg::F32_QNAN;
        end else if (a_inf || b_inf) begin
            n_spec_val = {n_sign, 8'hFF, 23'b0};
        end else if (a_zero || b_zero) begin
            n_spec_val = {n_sign, 31'b0};
        end else begin
            n_spec     = 1'b0;
            n_spec_val = '0;
        end
    end

    // normalize, denormalize on underflow, round to nearest even
    always_comb begin
        if (r2_p[47]) begin
            pn = r2_p;
            e  = r2_e + 12'sd1;
        end else begin
            pn = r2_p << 1;
            e  = r2_e;
        end
        if (e >= 12'sd1) begin
            sh    = 6'd0;
            field = e[7:0];
        end else begin
            sh    = (12'sd1 - e > 12'sd48) ? 6'd48 : 6'(12'sd1 - e);
            field = 8'd0;
        end
        m    = pn >> sh;
        lost = |(pn & ~({48{1'b1}} << sh));
        up   = m[23] & (lost | (|m[22:0]) | m[24]);
        if (r2_spec) begin
            n_res = r2_spec_val;
        end else if (e >= 12'sd255) begin
            n_res = {r2_sign, 8'hFF, 23'b0};
        end else begin
            n_res = {r2_sign, 31'({field, m[46:24]}) + 31'(up)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sign     <= n_sign;
            r1_spec     <= n_spec;
            r1_spec_val <= n_spec_val;
            r1_ea       <= n_ea;
            r1_eb       <= n_eb;
            r1_ma       <= sig_a << lz_a;
            r1_mb       <= sig_b << lz_b;
            r2_sign     <= r1_sign;
            r2_spec     <= r1_spec;
            r2_spec_val <= r1_spec_val;
            r2_e        <= r1_ea + r1_eb - 12'(q6k_pkg::F32_BIAS);
            r2_p        <= r1_ma * r1_mb;
            r3_res      <= n_res;
        end
    end

    assign o_prod = r3_res;

endmodule

`default_nettype wire

/* rtl/core/q6k_fadd.sv */
`default_nettype none

module q6k_fadd (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_sum
);

    logic        a_nan, a_inf, b_nan, b_inf, swap;
    logic [31:0] big, sml;
    logic [7:0]  e_big, e_sml, d;
    logic [23:0] sig_big, sig_sml;
    logic [26:0] ms, al;
    logic        lost_al;
    logic        n_spec;
    logic [31:0] n_spec_val;

    logic        r1_sign, r1_sub, r1_spec;
    logic [31:0] r1_spec_val;
    logic [7:0]  r1_e;
    logic [26:0] r1_mb, r1_ms;

    logic        r2_sign, r2_sub, r2_spec;
    logic [31:0] r2_spec_val;
    logic [7:0]  r2_e;
    logic [27:0] r2_sum;

    logic [5:0]  lz;
    logic [7:0]  lim, sh;
    logic [26:0] m27;
    logic [8:0]  e9;
    logic [7:0]  field;
    logic        up;
    logic [31:0] n_sum;
    logic [31:0] r3_sum;

    // unpack, order by magnitude, align the smaller operand with sticky
    always_comb begin
        a_nan   = (i_a[30:23] == 8'hFF) && (i_a[22:0] != '0);
        a_inf   = (i_a[30:23] == 8'hFF) && (i_a[22:0] == '0);
        b_nan   = (i_b[30:23] == 8'hFF) && (i_b[22:0] != '0);
        b_inf   = (i_b[30:23] == 8'hFF) && (i_b[22:0] == '0);
        swap    = i_b[30:0] > i_a[30:0];
        big     = swap ? i_b : i_a;
        sml     = swap ? i_a : i_b;
        e_big   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        e_sml   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        sig_big = {big[30:23] != 8'd0, big[22:0]};
        sig_sml = {sml[30:23] != 8'd0, sml[22:0]};
        d       = e_big - e_sml;
        ms      = {sig_sml, 3'b0};
        if (d >= 8'd27) begin
            al      = '0;
            lost_al = sig_sml != '0;
        end else begin
            al      = ms >> d[4:0];
            lost_al = |(ms & ~({27{1'b1}} << d[4:0]));
        end
        al[0]  = al[0] | lost_al;
        n_spec = 1'b1;
        priority if (a_nan) begin
            n_spec_val = i_a | q6k_pkg::F32_QUIET;
        end else if (b_nan) begin
            n_spec_val = i_b | q6k_pkg::F32_QUIET;
        end else if (a_inf && b_inf && (i_a[31] != i_b[31])) begin
            n_spec_val = q6k_pkg::F32_QNAN;
        end else if (a_inf) begin
            n_spec_val = i_a;
        end else if (b_inf) begin
            n_spec_val = i_b;
        end else begin
            n_spec     = 1'b0;
            n_spec_val = '0;
        end
    end

    // normalize (no lower than the subnormal exponent), round, pack
    always_comb begin
        lz  = q6k_pkg::f_lzc32({r2_sum[26:0], 5'b0});
        lim = r2_e - 8'd1;
        sh  = ({2'b0, lz} < lim) ? {2'b0, lz} : lim;
        if (r2_sum[27]) begin
            m27 = {r2_sum[27:2], r2_sum[1] | r2_sum[0]};
            e9  = {1'b0, r2_e} + 9'd1;
        end else begin
            m27 = r2_sum[26:0] << sh;
            e9  = {1'b0, r2_e} - {1'b0, sh};
        end
        field = m27[26] ? e9[7:0] : 8'd0;
        up    = m27[2] & (m27[1] | m27[0] | m27[3]);
        if (r2_spec) begin
            n_sum = r2_spec_val;
        end else if (r2_sum == '0) begin
            // exact cancel gives +0, two like-signed zeros keep their sign
            n_sum = {r2_sign & ~r2_sub, 31'b0};
        end else if (e9 >= 9'd255) begin
            n_sum = {r2_sign, 8'hFF, 23'b0};
        end else begin
            n_sum = {r2_sign, 31'({field, m27[25:3]}) + 31'(up)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sign     <= big[31];
            r1_sub      <= i_a[31] ^ i_b[31];
            r1_spec     <= n_spec;
            r1_spec_val <= n_spec_val;
            r1_e        <= e_big;
            r1_mb       <= {sig_big, 3'b0};
            r1_ms       <= al;
            r2_sign     <= r1_sign;
            r2_sub      <= r1_sub;
            r2_spec     <= r1_spec;
            r2_spec_val <= r1_spec_val;
            r2_e        <= r1_e;
            r2_sum      <= r1_sub ? ({1'b0, r1_mb} - {1'b0, r1_ms})
                                  : ({1'b0, r1_mb} + {1'b0, r1_ms});
            r3_sum      <= n_sum;
        end
    end

    assign o_sum = r3_sum;

endmodule

`default_nettype wire

/* rtl/core/q6k_subblock_dot_accumulate_top.sv */
// throughput: one word per cycle when not stalled, set by the four lane accumulators and a
// float adder whose result is written back in time for the lane's next word
// the whole pipeline holds only while a row result waits at a full, stalled output
// reset clears valid bits, lane pointer, lane use mask and config (per-group on, scale 1.0)
`default_nettype none

module q6k_subblock_dot_accumulate_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // codes_low, codes_high, acts_low, acts_high, sub_scale, activation_sum,
    // super_scale_half, group_src_scale, 4 zero bits
    input  logic [q6k_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  logic                             s_axis_tlast,   // last_of_row
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [31:0]                      m_axis_tdata,   // row_result
    input  logic                             i_cfg_we,
    input  logic [q6k_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [31:0]                      i_cfg_wdata
);

    localparam int NCODE = q6k_pkg::SUB_WIDTH * q6k_pkg::CODE_W;
    localparam int NACT  = q6k_pkg::SUB_WIDTH * q6k_pkg::ACT_W;
    localparam int OFF_SC   = NCODE + NACT;
    localparam int OFF_ASUM = OFF_SC + 8;
    localparam int OFF_HALF = OFF_ASUM + 12;
    localparam int OFF_GSS  = OFF_HALF + 16;

    logic        r_per_group;
    logic [31:0] r_global_ss;

    logic        adv;
    logic [21:1] r_v;

    logic [31:0] r_df1, r_scf1;
    logic [31:0] r_ss   [1:7];
    logic        r_last [1:13];

    logic [31:0] diff_f, ds, term, prod;

    logic [q6k_pkg::LANE_W-1:0] r_ptr;
    logic [q6k_pkg::LANES-1:0]  r_used;
    logic [q6k_pkg::LANES-1:0]  n_mask;
    logic [31:0]                lane_rd;
    logic [31:0]                r_lane  [q6k_pkg::LANES];
    logic [q6k_pkg::LANE_W-1:0] r_lidx  [11:13];
    logic [q6k_pkg::LANES-1:0]  r_mask  [11:13];
    logic [31:0]                acc_sum;

    logic [31:0] r_red [q6k_pkg::LANES];
    logic [31:0] left_sum, right_sum, total;
    logic [31:0] r_left, r_right, r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_per_group <= 1'b1;
            r_global_ss <= q6k_pkg::F32_ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                q6k_pkg::REG_PER_GROUP: r_per_group <= i_cfg_wdata[0];
                q6k_pkg::REG_GLOBAL_SS: r_global_ss <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // only a row result meeting a held output stops the line
    assign adv           = !(r_v[21] && m_axis_tvalid && !m_axis_tready);
    assign s_axis_tready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v[1] <= s_axis_tvalid;
            for (int k = 2; k <= 21; k++) begin
                if (k == 14) begin
                    r_v[k] <= r_v[13] & r_last[13];
                end else begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    q6k_dot u_dot (
        .i_clk    (i_clk),
        .i_en     (adv),
        .i_codes  (s_axis_tdata[NCODE-1:0]),
        .i_acts   (s_axis_tdata[NCODE +: NACT]),
        .i_asum   ($signed(s_axis_tdata[OFF_ASUM +: 12])),
        .o_diff_f (diff_f)
    );

    // d times sub-block scale
    q6k_fmul u_mul_ds (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_a    (r_df1),
        .i_b    (r_scf1),
        .o_prod (ds)
    );

    q6k_fmul u_mul_term (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_a    (ds),
        .i_b    (diff_f),
        .o_prod (term)
    );

    q6k_fmul u_mul_ss (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_a    (r_ss[7]),
        .i_b    (term),
        .o_prod (prod)
    );

    // a lane not yet touched in this row reads as +0
    assign n_mask  = r_used | (q6k_pkg::LANES'(1) << r_ptr);
    assign lane_rd = r_used[r_ptr] ? r_lane[r_ptr] : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_used <= '0;
        end else if (adv && r_v[10]) begin
            r_ptr  <= r_last[10] ? '0 : r_ptr + 1'b1;
            r_used <= r_last[10] ? '0 : n_mask;
        end
    end

    q6k_fadd u_add_lane (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (lane_rd),
        .i_b   (prod),
        .o_sum (acc_sum)
    );

    q6k_fadd u_add_left (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (r_red[0]),
        .i_b   (r_red[1]),
        .o_sum (left_sum)
    );

    q6k_fadd u_add_right (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (r_red[2]),
        .i_b   (r_red[3]),
        .o_sum (right_sum)
    );

    q6k_fadd u_add_total (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (r_left),
        .i_b   (r_right),
        .o_sum (total)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_df1   <= q6k_pkg::f_half_to_f32(s_axis_tdata[OFF_HALF +: 16]);
            r_scf1  <= q6k_pkg::f_int_to_f32({{(q6k_pkg::DIFF_W-8){s_axis_tdata[OFF_SC+7]}},
                                              s_axis_tdata[OFF_SC +: 8]});
            r_ss[1] <= r_per_group ? s_axis_tdata[OFF_GSS +: 32] : r_global_ss;
            r_last[1] <= s_axis_tlast;
            for (int k = 2; k <= 7; k++) begin
                r_ss[k] <= r_ss[k-1];
            end
            for (int k = 2; k <= 13; k++) begin
                r_last[k] <= r_last[k-1];
            end
            r_lidx[11] <= r_ptr;
            r_mask[11] <= n_mask;
            for (int k = 12; k <= 13; k++) begin
                r_lidx[k] <= r_lidx[k-1];
                r_mask[k] <= r_mask[k-1];
            end
            if (r_v[13]) begin
                r_lane[r_lidx[13]] <= acc_sum;
            end
            // lane snapshot for the row end, with this word's sum in place
            for (int j = 0; j < q6k_pkg::LANES; j++) begin
                if (!r_mask[13][j]) begin
                    r_red[j] <= 32'h0;
                end else if (q6k_pkg::LANE_W'(j) == r_lidx[13]) begin
                    r_red[j] <= acc_sum;
                end else begin
                    r_red[j] <= r_lane[j];
                end
            end
            r_left  <= left_sum;
            r_right <= right_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (adv && r_v[21]) begin
            m_axis_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_v[21]) begin
            r_out <= total;
        end
    end

    assign m_axis_tdata = r_out;

endmodule

`default_nettype wire
